// ===== design/sukq_pkg.sv =====
package sukq_pkg;

  localparam int FIELD_W = 64;
  localparam int COUNT_W = 5;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_DUP   = 2'd1;
  localparam status_t ST_UNDER = 2'd2;
  localparam status_t ST_FULL  = 2'd3;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

endpackage

// ===== design/sorted_unique_key_queue_unit.sv =====
// records sit in a ring memory in key order, the head record is mirrored in registers
// pop: S_POP refreshes the head, S_FIN offers the result; in_ready returns as out_valid rises
// push: S_SCAN reads records scanning down from the tail; S_SHIFT moves each record above the
// insertion point up one slot, then writes the new record; a duplicate or full skips S_SHIFT
// a held result stalls the final state; one memory read and one write per cycle
// reset clears the count, the ring pointer and the handshake state; memory contents are not cleared
module sorted_unique_key_queue_unit import sukq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int KEY_BITS = 64,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic [FIELD_W-1:0] in_key,
  input  logic [FIELD_W-1:0] in_payload,
  output logic               out_valid,
  input  logic               out_ready,
  output status_t            out_status,
  output logic [FIELD_W-1:0] out_popped_key,
  output logic [FIELD_W-1:0] out_popped_payload,
  output logic [FIELD_W-1:0] out_head_key,
  output logic [FIELD_W-1:0] out_head_payload,
  output logic [COUNT_W-1:0] out_entry_count,
  output logic               out_is_empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int W  = KEY_BITS + PAYLOAD_BITS;

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [W-1:0]            mem_wdata;
  logic [AW-1:0]           mem_raddr;
  logic [W-1:0]            mem_rdata;
  logic                    res_valid;
  logic                    res_ready;
  status_t                 res_status;
  logic [KEY_BITS-1:0]     res_popped_key;
  logic [PAYLOAD_BITS-1:0] res_popped_payload;
  logic [KEY_BITS-1:0]     res_head_key;
  logic [PAYLOAD_BITS-1:0] res_head_payload;
  logic [CW-1:0]           res_count;
  logic [31:0]             cnt_ext;
  logic                    out_valid_r;

  sukq_rec_mem #(
    .DEPTH (DEPTH),
    .WIDTH (W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sukq_ctrl #(
    .DEPTH        (DEPTH),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (in_valid),
    .req_ready          (in_ready),
    .req_type           (in_req_type),
    .req_key            (in_key[KEY_BITS-1:0]),
    .req_payload        (in_payload[PAYLOAD_BITS-1:0]),
    .mem_we             (mem_we),
    .mem_waddr          (mem_waddr),
    .mem_wdata          (mem_wdata),
    .mem_raddr          (mem_raddr),
    .mem_rdata          (mem_rdata),
    .res_valid          (res_valid),
    .res_ready          (res_ready),
    .res_status         (res_status),
    .res_popped_key     (res_popped_key),
    .res_popped_payload (res_popped_payload),
    .res_head_key       (res_head_key),
    .res_head_payload   (res_head_payload),
    .res_count          (res_count)
  );

  assign res_ready = !out_valid_r || out_ready;
  assign cnt_ext   = 32'(res_count);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_status         <= res_status;
      out_popped_key     <= FIELD_W'(res_popped_key);
      out_popped_payload <= FIELD_W'(res_popped_payload);
      out_head_key       <= FIELD_W'(res_head_key);
      out_head_payload   <= FIELD_W'(res_head_payload);
      out_entry_count    <= cnt_ext[COUNT_W-1:0];
      out_is_empty       <= (res_count == '0);
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== design/sukq_rec_mem.sv =====
module sukq_rec_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/sukq_ctrl.sv =====
module sukq_ctrl import sukq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int KEY_BITS = 64,
  parameter int PAYLOAD_BITS = 64,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1),
  localparam int W = KEY_BITS + PAYLOAD_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    req_valid,
  output logic                    req_ready,
  input  logic                    req_type,
  input  logic [KEY_BITS-1:0]     req_key,
  input  logic [PAYLOAD_BITS-1:0] req_payload,
  output logic                    mem_we,
  output logic [AW-1:0]           mem_waddr,
  output logic [W-1:0]            mem_wdata,
  output logic [AW-1:0]           mem_raddr,
  input  logic [W-1:0]            mem_rdata,
  output logic                    res_valid,
  input  logic                    res_ready,
  output status_t                 res_status,
  output logic [KEY_BITS-1:0]     res_popped_key,
  output logic [PAYLOAD_BITS-1:0] res_popped_payload,
  output logic [KEY_BITS-1:0]     res_head_key,
  output logic [PAYLOAD_BITS-1:0] res_head_payload,
  output logic [CW-1:0]           res_count
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_POP   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [2:0]              state_r, state_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [AW-1:0]           head_ptr_r, head_ptr_nxt;
  logic [KEY_BITS-1:0]     head_key_r, head_key_nxt;
  logic [PAYLOAD_BITS-1:0] head_pay_r, head_pay_nxt;
  logic [KEY_BITS-1:0]     key_r, key_nxt;
  logic [PAYLOAD_BITS-1:0] pay_r, pay_nxt;
  logic [KEY_BITS-1:0]     pop_key_r, pop_key_nxt;
  logic [PAYLOAD_BITS-1:0] pop_pay_r, pop_pay_nxt;
  status_t                 status_r, status_nxt;
  logic [AW-1:0]           rd_idx_r, rd_idx_nxt;
  logic                    rd_more_r, rd_more_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]           rd_tag_r, rd_tag_nxt;
  logic [CW-1:0]           pos_r, pos_nxt;

  logic [KEY_BITS-1:0]     rd_key;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  logic                    found;
  logic [CW-1:0]           pos_c;
  logic [AW:0]             tag_inc;

  // logical slot to physical address in the ring
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [AW-1:0] idx);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, idx};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  assign rd_key  = mem_rdata[W-1 -: KEY_BITS];
  assign rd_pay  = mem_rdata[PAYLOAD_BITS-1:0];
  assign tag_inc = {1'b0, rd_tag_r} + (AW + 1)'(1);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    head_ptr_nxt = head_ptr_r;
    head_key_nxt = head_key_r;
    head_pay_nxt = head_pay_r;
    key_nxt      = key_r;
    pay_nxt      = pay_r;
    pop_key_nxt  = pop_key_r;
    pop_pay_nxt  = pop_pay_r;
    status_nxt   = status_r;
    rd_idx_nxt   = rd_idx_r;
    rd_more_nxt  = rd_more_r;
    rd_vld_nxt   = 1'b0;
    rd_tag_nxt   = rd_tag_r;
    pos_nxt      = pos_r;
    found        = 1'b0;
    pos_c        = '0;
    mem_we       = 1'b0;
    mem_waddr    = phys(head_ptr_r, tag_inc[AW-1:0]);
    mem_wdata    = mem_rdata;
    mem_raddr    = phys(head_ptr_r, rd_idx_r);
    res_valid    = 1'b0;

    case (state_r)
      S_IDLE: begin
        // prefetch the second record so a pop can refresh the head
        mem_raddr = phys(head_ptr_r, AW'(1));
        if (req_valid) begin
          key_nxt     = req_key;
          pay_nxt     = req_payload;
          pop_key_nxt = '0;
          pop_pay_nxt = '0;
          status_nxt  = ST_OK;
          if (req_type == REQ_PUSH) begin
            rd_idx_nxt  = AW'(cnt_r - CW'(1));
            rd_more_nxt = (cnt_r != '0);
            state_nxt   = S_SCAN;
          end else if (cnt_r == '0) begin
            status_nxt = ST_UNDER;
            state_nxt  = S_FIN;
          end else begin
            pop_key_nxt = head_key_r;
            pop_pay_nxt = head_pay_r;
            state_nxt   = S_POP;
          end
        end
      end
      S_POP: begin
        head_key_nxt = rd_key;
        head_pay_nxt = rd_pay;
        head_ptr_nxt = phys(head_ptr_r, AW'(1));
        cnt_nxt      = cnt_r - CW'(1);
        state_nxt    = S_FIN;
      end
      S_SCAN: begin
        // walk down from the tail, one read issued per cycle
        if (rd_more_r) begin
          rd_vld_nxt  = 1'b1;
          rd_tag_nxt  = rd_idx_r;
          rd_idx_nxt  = rd_idx_r - AW'(1);
          rd_more_nxt = (rd_idx_r != '0);
        end
        if (rd_vld_r) begin
          if (rd_key == key_r) begin
            status_nxt = ST_DUP;
            state_nxt  = S_FIN;
          end else if (rd_key < key_r) begin
            found = 1'b1;
            pos_c = CW'(tag_inc);
          end else if (rd_tag_r == '0) begin
            found = 1'b1;
          end
        end else if (!rd_more_r) begin
          found = 1'b1;
        end
        if (found) begin
          pos_nxt = pos_c;
          if (cnt_r == DEPTH_C) begin
            status_nxt = ST_FULL;
            state_nxt  = S_FIN;
          end else begin
            rd_idx_nxt  = AW'(cnt_r - CW'(1));
            rd_more_nxt = (cnt_r != pos_c);
            rd_vld_nxt  = 1'b0;
            state_nxt   = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        // move each record above the insertion point up by one slot
        if (rd_more_r) begin
          rd_vld_nxt  = 1'b1;
          rd_tag_nxt  = rd_idx_r;
          rd_idx_nxt  = rd_idx_r - AW'(1);
          rd_more_nxt = (CW'(rd_idx_r) != pos_r);
        end
        if (rd_vld_r) begin
          mem_we = 1'b1;
        end else if (!rd_more_r) begin
          mem_we    = 1'b1;
          mem_waddr = phys(head_ptr_r, AW'(pos_r));
          mem_wdata = {key_r, pay_r};
          cnt_nxt   = cnt_r + CW'(1);
          if (pos_r == '0) begin
            head_key_nxt = key_r;
            head_pay_nxt = pay_r;
          end
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      head_ptr_r <= '0;
      rd_more_r  <= 1'b0;
      rd_vld_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      head_ptr_r <= head_ptr_nxt;
      rd_more_r  <= rd_more_nxt;
      rd_vld_r   <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_key_r <= head_key_nxt;
    head_pay_r <= head_pay_nxt;
    key_r      <= key_nxt;
    pay_r      <= pay_nxt;
    pop_key_r  <= pop_key_nxt;
    pop_pay_r  <= pop_pay_nxt;
    status_r   <= status_nxt;
    rd_idx_r   <= rd_idx_nxt;
    rd_tag_r   <= rd_tag_nxt;
    pos_r      <= pos_nxt;
  end

  assign req_ready          = (state_r == S_IDLE);
  assign res_status         = status_r;
  assign res_popped_key     = pop_key_r;
  assign res_popped_payload = pop_pay_r;
  assign res_head_key       = (cnt_r == '0) ? '0 : head_key_r;
  assign res_head_payload   = (cnt_r == '0) ? '0 : head_pay_r;
  assign res_count          = cnt_r;

endmodule

// ===== tb/sorted_unique_key_queue_unit_tb.sv =====
module sorted_unique_key_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sukq_pkg::*;

  localparam int DEPTH = 16;
  localparam int KEY_BITS = 64;
  localparam int PAYLOAD_BITS = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    status_t            status;
    logic [FIELD_W-1:0] popped_key;
    logic [FIELD_W-1:0] popped_payload;
    logic [FIELD_W-1:0] head_key;
    logic [FIELD_W-1:0] head_payload;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
  } queue_outcome_t;

  class key_order_store;
    logic [FIELD_W-1:0] held_keys [DEPTH];
    logic [FIELD_W-1:0] held_payloads [DEPTH];
    int held_count = 0;
    queue_outcome_t awaited_outcomes [$];
    int mismatches = 0;
    int failures = 0;

    function void note_request(logic req_type, logic [FIELD_W-1:0] key,
                               logic [FIELD_W-1:0] payload);
      logic [FIELD_W-1:0] k;
      logic [FIELD_W-1:0] p;
      queue_outcome_t o;
      int pos;
      bit dup;
      k = key & ({FIELD_W{1'b1}} >> (FIELD_W - KEY_BITS));
      p = payload & ({FIELD_W{1'b1}} >> (FIELD_W - PAYLOAD_BITS));
      o.status = ST_OK;
      o.popped_key = '0;
      o.popped_payload = '0;
      if (req_type == REQ_PUSH) begin
        pos = 0;
        dup = 1'b0;
        for (int i = 0; i < held_count; i++) begin
          if (held_keys[i] == k) dup = 1'b1;
          if (held_keys[i] < k) pos = i + 1;
        end
        if (dup) begin
          o.status = ST_DUP;
        end else if (held_count >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          for (int i = held_count; i > pos; i--) begin
            held_keys[i] = held_keys[i-1];
            held_payloads[i] = held_payloads[i-1];
          end
          held_keys[pos] = k;
          held_payloads[pos] = p;
          held_count++;
        end
      end else if (held_count == 0) begin
        o.status = ST_UNDER;
      end else begin
        o.popped_key = held_keys[0];
        o.popped_payload = held_payloads[0];
        for (int i = 1; i < held_count; i++) begin
          held_keys[i-1] = held_keys[i];
          held_payloads[i-1] = held_payloads[i];
        end
        held_count--;
      end
      o.head_key = (held_count != 0) ? held_keys[0] : '0;
      o.head_payload = (held_count != 0) ? held_payloads[0] : '0;
      o.entry_count = COUNT_W'(held_count);
      o.is_empty = (held_count == 0);
      awaited_outcomes.push_back(o);
    endfunction

    function void check_result(queue_outcome_t got);
      queue_outcome_t want;
      if (awaited_outcomes.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d head %h count %0d",
                   got.status, got.head_key, got.entry_count);
        return;
      end
      want = awaited_outcomes.pop_front();
      if (got !== want) begin
        failures++;
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch expected: st %0d pop %h/%h head %h/%h cnt %0d emp %0d",
                   want.status, want.popped_key, want.popped_payload, want.head_key,
                   want.head_payload, want.entry_count, want.is_empty);
          $display("         actual:   st %0d pop %h/%h head %h/%h cnt %0d emp %0d",
                   got.status, got.popped_key, got.popped_payload, got.head_key,
                   got.head_payload, got.entry_count, got.is_empty);
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_req_type = REQ_PUSH;
  logic [FIELD_W-1:0] in_key = '0;
  logic [FIELD_W-1:0] in_payload = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  status_t            out_status;
  logic [FIELD_W-1:0] out_popped_key;
  logic [FIELD_W-1:0] out_popped_payload;
  logic [FIELD_W-1:0] out_head_key;
  logic [FIELD_W-1:0] out_head_payload;
  logic [COUNT_W-1:0] out_entry_count;
  logic               out_is_empty;

  int idle_in_pct = 22;
  int idle_out_pct = 83;
  int cycle_count = 0;
  logic [FIELD_W-1:0] recent_keys [$];
  queue_outcome_t seen_outcome;
  key_order_store board;

  sorted_unique_key_queue_unit #(
    .DEPTH(DEPTH),
    .KEY_BITS(KEY_BITS),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req_type(in_req_type),
    .in_key(in_key),
    .in_payload(in_payload),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_popped_key(out_popped_key),
    .out_popped_payload(out_popped_payload),
    .out_head_key(out_head_key),
    .out_head_payload(out_head_payload),
    .out_entry_count(out_entry_count),
    .out_is_empty(out_is_empty)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= idle_out_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL sorted_unique_key_queue_unit");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      seen_outcome.status = out_status;
      seen_outcome.popped_key = out_popped_key;
      seen_outcome.popped_payload = out_popped_payload;
      seen_outcome.head_key = out_head_key;
      seen_outcome.head_payload = out_head_payload;
      seen_outcome.entry_count = out_entry_count;
      seen_outcome.is_empty = out_is_empty;
      board.check_result(seen_outcome);
    end
  end

  task automatic send_request(input logic req_type, input logic [FIELD_W-1:0] key,
                              input logic [FIELD_W-1:0] payload);
    @(negedge clk);
    while ($urandom_range(99) < idle_in_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req_type;
    in_key <= key;
    in_payload <= payload;
    do @(posedge clk); while (!in_ready);
    board.note_request(req_type, key, payload);
    if (req_type == REQ_PUSH) begin
      recent_keys.push_back(key);
      if (recent_keys.size() > 24) recent_keys.delete(0);
    end
  endtask

  // bursts lean towards filling, draining or an even mix
  task automatic random_requests(input int n);
    int left;
    int burst;
    int push_pct;
    int sel;
    logic op;
    logic [FIELD_W-1:0] k;
    logic [FIELD_W-1:0] p;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(30, 4);
      case ($urandom_range(2))
        0: push_pct = 85;
        1: push_pct = 15;
        default: push_pct = 55;
      endcase
      for (int j = 0; j < burst && left > 0; j++) begin
        op = ($urandom_range(99) < push_pct) ? REQ_PUSH : REQ_POP;
        sel = $urandom_range(99);
        if (sel < 25 && recent_keys.size() > 0)
          k = recent_keys[$urandom_range(recent_keys.size() - 1)];
        else if (sel < 40)
          k = FIELD_W'($urandom_range(15));
        else if (sel < 45)
          k = sel[0] ? {FIELD_W{1'b1}} : {FIELD_W{1'b0}};
        else
          k = {$urandom, $urandom};
        if ($urandom_range(19) == 0)
          p = $urandom_range(1) ? {FIELD_W{1'b1}} : {FIELD_W{1'b0}};
        else
          p = {$urandom, $urandom};
        send_request(op, k, p);
        left--;
      end
    end
  endtask

  initial begin
    board = new;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // underflow, extreme keys, a duplicate, then fill to the top
    send_request(REQ_POP, '0, '0);
    send_request(REQ_PUSH, {FIELD_W{1'b1}}, '0);
    send_request(REQ_PUSH, '0, {FIELD_W{1'b1}});
    send_request(REQ_PUSH, '0, 64'h1234);
    send_request(REQ_POP, {FIELD_W{1'b1}}, {FIELD_W{1'b1}});
    send_request(REQ_PUSH, 64'h8000_0000_0000_0000, 64'ha5a5_a5a5_a5a5_a5a5);
    send_request(REQ_PUSH, 64'h7fff_ffff_ffff_ffff, 64'h5a5a_5a5a_5a5a_5a5a);
    send_request(REQ_POP, '0, '0);
    for (int i = 1; i <= 14; i++)
      send_request(REQ_PUSH, {8'(i), 48'h0, 8'(i)}, {$urandom, $urandom});
    send_request(REQ_PUSH, 64'h0123_4567_89ab_cdef, {$urandom, $urandom});
    send_request(REQ_PUSH, {FIELD_W{1'b1}}, {$urandom, $urandom});
    send_request(REQ_POP, '0, '0);

    random_requests(215);
    idle_in_pct = 83;
    idle_out_pct = 22;
    random_requests(215);
    idle_in_pct = 0;
    idle_out_pct = 0;
    random_requests(220);

    @(negedge clk);
    in_valid <= 1'b0;
    while (board.awaited_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (board.failures == 0)
      $display("PASS sorted_unique_key_queue_unit");
    else
      $display("FAIL sorted_unique_key_queue_unit");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/sukq_pkg.sv
design/sukq_rec_mem.sv
design/sukq_ctrl.sv
design/sorted_unique_key_queue_unit.sv
tb/sorted_unique_key_queue_unit_tb.sv
